/* rtl/core/ffha_pkg.sv */
`timescale 1ns / 1ps
package ffha_pkg;

  // defaults for the top level parameters
  localparam int unsigned HeapWordsDef   = 1024;
  localparam int unsigned HeaderWordsDef = 1;

  // fixed field widths
  localparam int unsigned OpW   = 2;
  localparam int unsigned ReqW  = 11;
  localparam int unsigned AddrW = 10;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned StW   = 3;

  localparam logic [CfgW-1:0] CfgReset = 11'd1024;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [StW-1:0] {
    ST_OK            = 3'd0,
    ST_NO_FIT        = 3'd1,
    ST_BAD_ADDR      = 3'd2,
    ST_NOT_USED      = 3'd3,
    ST_BAD_SIZE      = 3'd4,
    ST_RESET_REFUSED = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_NEV,
    S_WR2,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] granted;
  } rsp_t;

endpackage

/* rtl/core/ffha_if.sv */
`timescale 1ns / 1ps
interface ffha_op_if;
  logic                         valid;
  logic                         ready;
  logic [ffha_pkg::OpW-1:0]     opcode;
  logic [ffha_pkg::ReqW-1:0]    request_size;
  logic [ffha_pkg::AddrW-1:0]   block_address;
  modport source (output valid, opcode, request_size, block_address, input ready);
  modport sink (input valid, opcode, request_size, block_address, output ready);
endinterface

interface ffha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffha_pkg::StW-1:0]     status;
  logic [ffha_pkg::AddrW-1:0]   granted_address;
  modport source (output valid, status, granted_address, input ready);
  modport sink (input valid, status, granted_address, output ready);
endinterface

interface ffha_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ffha_pkg::CfgW-1:0]    heap_words_in_use;
  modport source (output valid, heap_words_in_use, input ready);
  modport sink (input valid, heap_words_in_use, output ready);
endinterface

/* rtl/core/ffha_mem.sv */
`timescale 1ns / 1ps
module ffha_mem #(
  parameter int unsigned          DEPTH = 1024,
  parameter int unsigned          AW    = 10,
  parameter int unsigned          HW    = 12,
  parameter logic [HW-1:0]        INIT0 = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [HW-1:0] rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [HW-1:0] wdata_i
);
  logic [HW-1:0] mem_q [DEPTH];
  logic [HW-1:0] rdata_q;
  logic          fresh_q;
  logic          init_hit_q;

  // word 0 reads as the reset header until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
    end else if (we_i && (waddr_i == '0)) begin
      fresh_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q    <= mem_q[raddr_i];
      init_hit_q <= fresh_q && (raddr_i == '0);
    end
  end

  assign rdata_o = init_hit_q ? INIT0 : rdata_q;
endmodule

/* rtl/core/ffha_alu.sv */
`timescale 1ns / 1ps
module ffha_alu #(
  parameter int unsigned SZW          = 11,
  parameter int unsigned NW           = 12,
  parameter int unsigned HEADER_WORDS = 1
) (
  input  logic [SZW-1:0]              pos_i,
  input  logic [SZW-1:0]              active_i,
  input  logic [SZW-1:0]              sz_i,
  input  logic [NW-1:0]               need_i,
  input  logic [ffha_pkg::AddrW-1:0]  addr_i,
  output logic                        in_range_o,
  output logic                        bad_o,
  output logic                        fits_o,
  output logic                        split_o,
  output logic [SZW-1:0]              left_o,
  output logic [SZW-1:0]              next_pos_o,
  output logic                        next_in_o,
  output logic [NW-1:0]               pos_hdr_o,
  output logic                        hit_o,
  output logic                        past_o
);
  logic [NW-1:0] pos_x, act_x, sz_x, limit, nxt_x, left_x;

  always_comb begin
    pos_x      = NW'(pos_i);
    act_x      = NW'(active_i);
    sz_x       = NW'(sz_i);
    limit      = act_x - pos_x;
    nxt_x      = pos_x + sz_x;
    left_x     = sz_x - need_i;
    in_range_o = pos_x < act_x;
    // zero size or a block running past the heap end ends the walk
    bad_o      = (sz_x == '0) || (sz_x > limit);
    fits_o     = sz_x >= need_i;
    split_o    = left_x > NW'(HEADER_WORDS);
    left_o     = left_x[SZW-1:0];
    next_pos_o = nxt_x[SZW-1:0];
    next_in_o  = nxt_x < act_x;
    pos_hdr_o  = pos_x + NW'(HEADER_WORDS);
    hit_o      = pos_hdr_o == NW'(addr_i);
    past_o     = pos_hdr_o > NW'(addr_i);
  end
endmodule

/* rtl/core/ffha_seq.sv */
`timescale 1ns / 1ps
module ffha_seq #(
  parameter int unsigned HEAP_WORDS   = 1024,
  parameter int unsigned HEADER_WORDS = 1,
  parameter int unsigned SZW          = 11,
  parameter int unsigned AW           = 10,
  parameter int unsigned NW           = 12,
  parameter int unsigned ACT_INIT     = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ffha_pkg::OpW-1:0]      opcode_i,
  input  logic [ffha_pkg::ReqW-1:0]     req_i,
  input  logic [ffha_pkg::AddrW-1:0]    addr_i,
  input  logic [ffha_pkg::CfgW-1:0]     cfg_words_i,
  output logic                          idle_o,
  output logic                          done_o,
  output ffha_pkg::rsp_t                rsp_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [SZW:0]                  mem_rdata_i,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [SZW:0]                  mem_wdata_o
);
  import ffha_pkg::*;

  state_e           state_q, state_d;
  opcode_e          op_q, op_d;
  logic [NW-1:0]    need_q, need_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [SZW-1:0]   pos_q, pos_d, active_q, active_d;
  logic [SZW-1:0]   prev_q, prev_d, prev_sz_q, prev_sz_d;
  logic             prev_free_q, prev_free_d;
  logic [SZW-1:0]   start_q, start_d, total_q, total_d;
  status_e          status_q, status_d;
  logic [AddrW-1:0] granted_q, granted_d;
  logic [SZW-1:0]   wr_addr_q, wr_addr_d;
  logic [SZW:0]     wr_data_q, wr_data_d;

  logic           hdr_used;
  logic [SZW-1:0] hdr_sz;
  logic           in_range, bad, fits, split, next_in, hit, past;
  logic [SZW-1:0] left, next_pos;
  logic [NW-1:0]  pos_hdr, words_x;
  logic [SZW-1:0] m_start, m_total;

  assign hdr_used = mem_rdata_i[SZW];
  assign hdr_sz   = mem_rdata_i[SZW-1:0];

  ffha_alu #(
    .SZW(SZW), .NW(NW), .HEADER_WORDS(HEADER_WORDS)
  ) u_alu (
    .pos_i(pos_q), .active_i(active_q), .sz_i(hdr_sz), .need_i(need_q),
    .addr_i(addr_q), .in_range_o(in_range), .bad_o(bad), .fits_o(fits),
    .split_o(split), .left_o(left), .next_pos_o(next_pos), .next_in_o(next_in),
    .pos_hdr_o(pos_hdr), .hit_o(hit), .past_o(past)
  );

  // merge with a free block right before
  assign m_start = prev_free_q ? prev_q : pos_q;
  assign m_total = prev_free_q ? (prev_sz_q + hdr_sz) : hdr_sz;

  // saturated heap size for the reset operation
  assign words_x = (NW'(cfg_words_i) > NW'(HEAP_WORDS)) ? NW'(HEAP_WORDS) : NW'(cfg_words_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= SZW'(ACT_INIT);
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    need_q      <= need_d;
    addr_q      <= addr_d;
    pos_q       <= pos_d;
    prev_q      <= prev_d;
    prev_sz_q   <= prev_sz_d;
    prev_free_q <= prev_free_d;
    start_q     <= start_d;
    total_q     <= total_d;
    status_q    <= status_d;
    granted_q   <= granted_d;
    wr_addr_q   <= wr_addr_d;
    wr_data_q   <= wr_data_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (opcode_e'(opcode_i))
            OP_ALLOC: state_d = (req_i == '0) ? S_DONE : S_RD;
            OP_FREE:  state_d = (addr_i == '0) ? S_DONE : S_RD;
            OP_RESET: state_d = S_RD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_RD: state_d = in_range ? S_EV : S_FIN;
      S_EV: begin
        if (bad) begin
          state_d = S_FIN;
        end else begin
          case (op_q)
            OP_ALLOC: state_d = (!hdr_used && fits) ? (split ? S_WR2 : S_DONE) : S_RD;
            OP_FREE: begin
              if (hit) begin
                state_d = (hdr_used && next_in) ? S_NEV : S_DONE;
              end else begin
                state_d = past ? S_FIN : S_RD;
              end
            end
            OP_RESET: state_d = hdr_used ? S_DONE : S_RD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_NEV, S_WR2, S_FIN: state_d = S_DONE;
      S_DONE:              state_d = S_IDLE;
      default:             state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d        = op_q;
    need_d      = need_q;
    addr_d      = addr_q;
    pos_d       = pos_q;
    prev_d      = prev_q;
    prev_sz_d   = prev_sz_q;
    prev_free_d = prev_free_q;
    start_d     = start_q;
    total_d     = total_q;
    status_d    = status_q;
    granted_d   = granted_q;
    wr_addr_d   = wr_addr_q;
    wr_data_d   = wr_data_q;
    active_d    = active_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = pos_q[AW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q[AW-1:0];
    mem_wdata_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d        = opcode_e'(opcode_i);
          need_d      = NW'(req_i) + NW'(HEADER_WORDS);
          addr_d      = addr_i;
          pos_d       = '0;
          prev_free_d = 1'b0;
          granted_d   = '0;
          status_d    = ((opcode_e'(opcode_i) == OP_ALLOC) && (req_i == '0)) ? ST_BAD_SIZE
                                                                             : ST_OK;
        end
      end
      S_RD: mem_re_o = in_range;
      S_EV: begin
        if (!bad) begin
          case (op_q)
            OP_ALLOC: begin
              if (!hdr_used && fits) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = {1'b1, split ? need_q[SZW-1:0] : hdr_sz};
                granted_d   = pos_hdr[AddrW-1:0];
                status_d    = ST_OK;
                wr_addr_d   = pos_q + need_q[SZW-1:0];
                wr_data_d   = {1'b0, left};
              end else begin
                pos_d = next_pos;
              end
            end
            OP_FREE: begin
              if (hit) begin
                if (!hdr_used) begin
                  status_d = ST_NOT_USED;
                end else if (next_in) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = next_pos[AW-1:0];
                  pos_d       = next_pos;
                  start_d     = m_start;
                  total_d     = m_total;
                end else begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = m_start[AW-1:0];
                  mem_wdata_o = {1'b0, m_total};
                  status_d    = ST_OK;
                end
              end else begin
                prev_d      = pos_q;
                prev_sz_d   = hdr_sz;
                prev_free_d = !hdr_used;
                pos_d       = next_pos;
              end
            end
            OP_RESET: begin
              if (hdr_used) begin
                status_d = ST_RESET_REFUSED;
              end else begin
                pos_d = next_pos;
              end
            end
            default: status_d = ST_OK;
          endcase
        end
      end
      S_NEV: begin
        // merge with a free block right after
        mem_we_o    = 1'b1;
        mem_waddr_o = start_q[AW-1:0];
        mem_wdata_o = {1'b0, (!bad && !hdr_used) ? (total_q + hdr_sz) : total_q};
        status_d    = ST_OK;
      end
      S_WR2: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = wr_addr_q[AW-1:0];
        mem_wdata_o = wr_data_q;
      end
      S_FIN: begin
        case (op_q)
          OP_ALLOC: status_d = ST_NO_FIT;
          OP_FREE:  status_d = ST_BAD_ADDR;
          OP_RESET: begin
            if (words_x < NW'(HEADER_WORDS)) begin
              status_d = ST_RESET_REFUSED;
            end else begin
              active_d    = words_x[SZW-1:0];
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              mem_wdata_o = {1'b0, words_x[SZW-1:0]};
              status_d    = ST_OK;
            end
          end
          default: status_d = ST_OK;
        endcase
      end
      default: ;
    endcase
  end

  assign idle_o         = state_q == S_IDLE;
  assign done_o         = state_q == S_DONE;
  assign rsp_o.status   = status_q;
  assign rsp_o.granted  = granted_q;
endmodule

/* rtl/core/first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// channel  | dir | handshake    | payload
// op_i     | in  | valid/ready  | opcode, request_size, block_address
// rsp_o    | out | valid/ready  | status, granted_address
// cfg_i    | in  | valid/ready  | heap_words_in_use (always ready)
//
// one operation at a time: allocate, free and reset each walk the block chain,
// reading each header from the registered memory and then evaluating it, then a
// closing state, plus an extra state for a split, a merge with the following block or a
// walk that ends without a hit; the result is registered and then shows on rsp_o
// reset: the heap comes up as one free block; word 0 reads from a reset flag
// until first written, no clearing pass is needed
// op_i is not ready while a walk runs or while a result waits on rsp_o, and is
// ready again the cycle after the result transfer
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_WORDS   = ffha_pkg::HeapWordsDef,
  parameter int unsigned HEADER_WORDS = ffha_pkg::HeaderWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffha_op_if.sink     op_i,
  ffha_rsp_if.source  rsp_o,
  ffha_cfg_if.sink    cfg_i
);
  import ffha_pkg::*;

  // size field holds the full heap length, one used bit on top
  localparam int unsigned SzW      = $clog2(HEAP_WORDS + 1);
  localparam int unsigned AW       = $clog2(HEAP_WORDS);
  localparam int unsigned NW       = ((SzW > ReqW) ? SzW : ReqW) + 1;
  localparam int unsigned ActInit  = (HEAP_WORDS < int'(CfgReset)) ? HEAP_WORDS
                                                                   : int'(CfgReset);
  localparam logic [SzW:0] Init0   = {1'b0, SzW'(ActInit)};

  logic [CfgW-1:0] heap_words_q;
  logic            rsp_valid_q;
  rsp_t            rsp_q, seq_rsp;
  logic            seq_idle, seq_done, start;
  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  logic [SzW:0]    mem_rdata, mem_wdata;

  // configuration register, taken effect at the next reset operation
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_words_q <= CfgReset;
    end else if (cfg_i.valid) begin
      heap_words_q <= cfg_i.heap_words_in_use;
    end
  end

  assign op_i.ready = seq_idle && !rsp_valid_q;
  assign start      = op_i.valid && op_i.ready;

  ffha_seq #(
    .HEAP_WORDS(HEAP_WORDS), .HEADER_WORDS(HEADER_WORDS), .SZW(SzW), .AW(AW),
    .NW(NW), .ACT_INIT(ActInit)
  ) u_seq (
    .clk_i, .rst_ni, .start_i(start), .opcode_i(op_i.opcode),
    .req_i(op_i.request_size), .addr_i(op_i.block_address),
    .cfg_words_i(heap_words_q), .idle_o(seq_idle), .done_o(seq_done),
    .rsp_o(seq_rsp), .mem_re_o(mem_re), .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata), .mem_we_o(mem_we), .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata)
  );

  // header store, one word per heap word
  ffha_mem #(
    .DEPTH(HEAP_WORDS), .AW(AW), .HW(SzW + 1), .INIT0(Init0)
  ) u_mem (
    .clk_i, .rst_ni, .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(mem_rdata),
    .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata)
  );

  // result register toward the sink
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (seq_done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      rsp_q <= seq_rsp;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_q.status;
  assign rsp_o.granted_address = rsp_q.granted;

  // a finished walk always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni) seq_done |=> rsp_valid_q)
    else $error("finished operation not presented");

  // no result can appear the cycle right after a transfer on op_i
  assert property (@(posedge clk_i) disable iff (!rst_ni) start |=> !rsp_valid_q)
    else $error("result without a walk");

  // a granted address only comes with status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.granted != '0)) |-> (rsp_q.status == ST_OK))
    else $error("address granted on failure");
endmodule
